// ===== hdl/gwm_pkg.sv =====
// Shared types, constants and helper function of the glob wildcard matcher.
package gwm_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned CHAR_BITS_DEF   = 16;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned CODE_W = 16;

  localparam logic [31:0] CH_STAR    = 32'd42;
  localparam logic [31:0] CH_QUEST   = 32'd63;
  localparam logic [31:0] CH_UPPER_A = 32'd65;
  localparam logic [31:0] CH_UPPER_Z = 32'd90;
  localparam logic [31:0] CASE_DELTA = 32'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SOURCE = 2'd2,
    KIND_END    = 2'd3
  } gwm_kind_e;

  typedef struct packed {
    logic clr;
    logic app;
  } gwm_wr_t;

  function automatic logic [31:0] fold_char(logic [31:0] c, logic case_sensitive);
    logic [31:0] r;
    r = c;
    if (!case_sensitive && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ===== hdl/gwm_in_if.sv =====
// Input channel of the glob wildcard matcher: kind and character code.
interface gwm_in_if;
  import gwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] char_code;

  modport source(output valid, output kind, output char_code, input ready);
  modport sink(input valid, input kind, input char_code, output ready);
endinterface

// ===== hdl/gwm_out_if.sv =====
// Result channel of the glob wildcard matcher: match and overflow flags.
interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source(output valid, output matched, output pattern_overflow, input ready);
  modport sink(input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== hdl/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher with '*' and '?' over a streamed source string.
//
//   Channel   Direction   Handshake          Payload
//   in_i      sink        valid / ready      kind, char_code
//   out_o     source      valid / ready      matched, pattern_overflow
//   cfg       write only  cfg_we_i           cfg_wdata_i (case_sensitive)
//
// Every transaction sits in the input register while the position update
// works on it, so one transaction is accepted per cycle at full rate.
// A result is registered in the result register when its end-of-string transaction leaves the input register.
// Only an end-of-string transaction waits on a stalled result register; others pass.
// Reset empties the pattern, clears the overflow flag and sets case_sensitive.
module glob_wildcard_matcher #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned CHAR_BITS   = gwm_pkg::CHAR_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  gwm_in_if.sink    in_i,
  gwm_out_if.source out_o
);
  import gwm_pkg::*;

  localparam int unsigned NPOS  = MAX_PATTERN + 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic                   case_q;
  logic                   s1_valid_q, s1_valid_d;
  gwm_kind_e              s1_kind_q;
  logic [CHAR_BITS-1:0]   s1_char_q;
  logic [31:0]            code_ext;
  logic                   in_ready;
  logic                   out_free;
  logic                   s1_fire;
  logic                   end_fire;
  logic [NPOS-1:0]        active_q, active_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_matched_q;
  logic                   out_ovf_q;
  gwm_wr_t                wr;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] len_mask;
  logic [LEN_W-1:0]       len;
  logic                   overflow;
  logic [NPOS-1:0]        next_pos;
  logic                   matched;

  assign code_ext = 32'(in_i.char_code);

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (out_free || (s1_kind_q != KIND_END));
  assign end_fire = s1_fire && (s1_kind_q == KIND_END);
  assign in_ready = !s1_valid_q || s1_fire;
  assign in_i.ready = in_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_q     <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case_q <= cfg_wdata_i;
      end
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_kind_q <= gwm_kind_e'(in_i.kind);
      s1_char_q <= code_ext[CHAR_BITS-1:0];
    end
  end

  assign wr.clr = s1_fire && (s1_kind_q == KIND_CLEAR);
  assign wr.app = s1_fire && (s1_kind_q == KIND_APPEND);

  gwm_pattern_store #(
    .MAX_PATTERN(MAX_PATTERN),
    .CHAR_BITS  (CHAR_BITS)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .char_i          (s1_char_q),
    .case_sensitive_i(case_q),
    .star_o          (star),
    .hit_o           (hit),
    .len_mask_o      (len_mask),
    .len_o           (len),
    .overflow_o      (overflow)
  );

  gwm_pos_update #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_update (
    .active_i  (active_q),
    .star_i    (star),
    .hit_i     (hit),
    .len_mask_i(len_mask),
    .len_i     (len),
    .next_o    (next_pos),
    .matched_o (matched)
  );

  always_comb begin
    active_d = active_q;
    if (s1_fire) begin
      case (s1_kind_q)
        KIND_SOURCE: active_d = next_pos;
        KIND_CLEAR,
        KIND_APPEND,
        KIND_END:    active_d = NPOS'(1);
        default:     active_d = NPOS'(1);
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (end_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= NPOS'(1);
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      out_matched_q <= matched;
      out_ovf_q     <= overflow;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = out_matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(end_fire))
    else $error("Result raised without an end-of-string transaction.");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_fire |=> (active_q == NPOS'(1)))
    else $error("Position set not restarted after end of string.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && (s1_kind_q == KIND_END) && out_valid_q && !out_o.ready))
    else $error("Input stalled without a blocked result.");

endmodule

// ===== hdl/gwm_pattern_store.sv =====
// Pattern register file with length and overflow tracking and per-entry compare.
module gwm_pattern_store #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned CHAR_BITS   = 16,
  localparam int unsigned LEN_W      = $clog2(MAX_PATTERN + 1),
  localparam int unsigned IDX_W      = $clog2(MAX_PATTERN)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gwm_pkg::gwm_wr_t       wr_i,
  input  logic [CHAR_BITS-1:0]   char_i,
  input  logic                   case_sensitive_i,
  output logic [MAX_PATTERN-1:0] star_o,
  output logic [MAX_PATTERN-1:0] hit_o,
  output logic [MAX_PATTERN-1:0] len_mask_o,
  output logic [LEN_W-1:0]       len_o,
  output logic                   overflow_o
);
  import gwm_pkg::*;

  logic [CHAR_BITS-1:0] mem_q [MAX_PATTERN];
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 ovf_q, ovf_d;
  logic                 full;
  logic [31:0]          src_fold;

  assign full = (len_q == LEN_W'(MAX_PATTERN));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (wr_i.clr) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (wr_i.app) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.app && !full) begin
      mem_q[len_q[IDX_W-1:0]] <= char_i;
    end
  end

  assign src_fold = fold_char(32'(char_i), case_sensitive_i);

  always_comb begin
    logic [31:0] pc;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      pc            = 32'(mem_q[p]);
      star_o[p]     = (pc == CH_STAR);
      hit_o[p]      = (pc == CH_QUEST) || (fold_char(pc, case_sensitive_i) == src_fold);
      len_mask_o[p] = (LEN_W'(p) < len_q);
    end
  end

  assign len_o      = len_q;
  assign overflow_o = ovf_q;

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("Overflow flag set while the pattern store is not full.");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_PATTERN))
    else $error("Pattern length beyond the store depth.");

endmodule

// ===== hdl/gwm_pos_update.sv =====
// Star closure over the live position set and the advance by one source character.
module gwm_pos_update #(
  parameter int unsigned MAX_PATTERN = 32,
  localparam int unsigned NPOS       = MAX_PATTERN + 1,
  localparam int unsigned LEN_W      = $clog2(MAX_PATTERN + 1),
  localparam int unsigned LVL        = $clog2(NPOS)
) (
  input  logic [NPOS-1:0]        active_i,
  input  logic [MAX_PATTERN-1:0] star_i,
  input  logic [MAX_PATTERN-1:0] hit_i,
  input  logic [MAX_PATTERN-1:0] len_mask_i,
  input  logic [LEN_W-1:0]       len_i,
  output logic [NPOS-1:0]        next_o,
  output logic                   matched_o
);

  logic [NPOS-1:0]        gen [LVL+1];
  logic [NPOS-1:0]        prop [LVL+1];
  logic [NPOS-1:0]        closed;
  logic [MAX_PATTERN-1:0] live;
  logic [MAX_PATTERN-1:0] stay;
  logic [MAX_PATTERN-1:0] adv;

  // A live star position also makes the next position live; runs of stars are
  // resolved by a log-depth prefix network.
  always_comb begin
    int d;
    gen[0]  = active_i;
    prop[0] = '0;
    for (int p = 1; p < NPOS; p++) begin
      prop[0][p] = star_i[p-1] & len_mask_i[p-1];
    end
    for (int lv = 0; lv < LVL; lv++) begin
      d = 1 << lv;
      for (int p = 0; p < NPOS; p++) begin
        if (p >= d) begin
          gen[lv+1][p]  = gen[lv][p] | (prop[lv][p] & gen[lv][p-d]);
          prop[lv+1][p] = prop[lv][p] & prop[lv][p-d];
        end else begin
          gen[lv+1][p]  = gen[lv][p];
          prop[lv+1][p] = 1'b0;
        end
      end
    end
  end

  assign closed = gen[LVL];
  assign live   = closed[MAX_PATTERN-1:0] & len_mask_i;
  assign stay   = live & star_i;
  assign adv    = live & ~star_i & hit_i;

  assign next_o    = {1'b0, stay} | {adv, 1'b0};
  assign matched_o = closed[len_i];

endmodule
